@@ src/ptms_pkg.sv @@
package ptms_pkg;

    // Clocking and prescaler of the PWM timer that the block drives
    localparam int unsigned CLOCK_HZ      = 16000000;
    localparam int unsigned PRESCALE_CODE = 4;

    // Melody table geometry
    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned POS_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths of the command and result words
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned HZ_W    = 16;
    localparam int unsigned VOL_W   = 8;
    localparam int unsigned REP_W   = 8;
    localparam int unsigned PWM_W   = 16;
    localparam int unsigned TICK_W  = 32;

    // Range limits and scale factors
    localparam int unsigned MAX_VOL  = 100;
    localparam int unsigned MAX_HZ   = 20000;
    localparam int unsigned MS_SCALE = 1000;
    localparam int unsigned CMP_STEP = 255;

    // Prescaled divisor: tone_hz times (PRESCALE_CODE + 1), fits in 19 bits
    localparam int unsigned PRE_W = HZ_W + $clog2(PRESCALE_CODE + 2);

    // Shared serial divider
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    // Quotient of (reload + 1) / 255 fits in 9 bits
    localparam int unsigned STEP_Q_W = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_TONE  = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_PLAY  = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_TIMED  = 2'd1,
        MODE_MELODY = 2'd2,
        MODE_CONT   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MEL_CHK,
        ST_MEL_GAP,
        ST_DEN,
        ST_DIV_CLK,
        ST_RATIO_GO,
        ST_DIV_STEP,
        ST_TICK_GO,
        ST_DIV_TICK,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        KIND_TONE,
        KIND_NOTE,
        KIND_GAP
    } calc_kind_t;

    typedef struct packed {
        logic [MS_W-1:0]  dur;
        logic [HZ_W-1:0]  hz;
        logic [VOL_W-1:0] vol;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ src/ptms_if.sv @@
// Command channel
interface ptms_req_if
    import ptms_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] entry_index;
    logic [MS_W-1:0]   duration_ms;
    logic [HZ_W-1:0]   tone_hz;
    logic [VOL_W-1:0]  volume_pct;
    logic [REP_W-1:0]  repeat_limit_in;
    logic [MS_W-1:0]   gap_ms;

    modport source (
        output valid, cmd, entry_index, duration_ms, tone_hz, volume_pct,
               repeat_limit_in, gap_ms,
        input  ready
    );

    modport sink (
        input  valid, cmd, entry_index, duration_ms, tone_hz, volume_pct,
               repeat_limit_in, gap_ms,
        output ready
    );
endinterface

// Result channel
interface ptms_rsp_if
    import ptms_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PWM_W-1:0] pwm_reload;
    logic [PWM_W-1:0] pwm_compare;
    logic             busy_res;
    logic             rejected;

    modport source (
        output valid, pwm_reload, pwm_compare, busy_res, rejected,
        input  ready
    );

    modport sink (
        input  valid, pwm_reload, pwm_compare, busy_res, rejected,
        output ready
    );
endinterface

@@ src/pwm_tone_melody_sequencer_core.sv @@
// Buzzer tone and melody sequencer. Each command word (tick, start tone, load
// melody entry, play melody, stop) gives exactly one result word with the PWM
// reload and compare values, busy and the reject flag of a failed start tone.
// Commands are taken one at a time; ready stays low while one is worked on.
// Tick, load, play, stop, unused codes and a rejected start tone go from decode
// straight to the result, and a tick that ends a melody passes the melody check.
// Start tone, a tick that fetches a melody note and a tick that starts a repeat
// gap take longer: the reload, the compare step and the note length each pass
// through the one shared 32-step serial divider. A finished result waits in the
// output register, so the next command may be accepted before the previous
// result is taken.
module pwm_tone_melody_sequencer_core
    import ptms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ptms_req_if.sink   req,
    ptms_rsp_if.source rsp
);

    // FSM and sequencer state
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [TICK_W-1:0]   tick_target_reg, tick_target_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [POS_W-1:0]    table_pos_reg, table_pos_next;
    logic [REP_W-1:0]    repeat_count_reg, repeat_count_next;
    logic [REP_W-1:0]    repeat_limit_reg, repeat_limit_next;
    logic [MS_W-1:0]     gap_length_reg, gap_length_next;
    logic                note_done_reg, note_done_next;
    logic                busy_flag_reg, busy_flag_next;
    logic [PWM_W-1:0]    reload_reg, reload_next;
    logic [PWM_W-1:0]    compare_reg, compare_next;
    logic                rej_reg, rej_next;

    // Latched command word
    logic [CMD_W-1:0]    cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [MS_W-1:0]     dur_reg;
    logic [HZ_W-1:0]     hz_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic [REP_W-1:0]    rep_reg;
    logic [MS_W-1:0]     gap_reg;

    // Operands and results of one tone calculation
    calc_kind_t          kind_reg, kind_next;
    logic [HZ_W-1:0]     calc_hz_reg, calc_hz_next;
    logic [VOL_W-1:0]    calc_vol_reg, calc_vol_next;
    logic [MS_W-1:0]     calc_len_reg, calc_len_next;
    logic [DIV_W-1:0]    full_reg, full_next;
    logic [PWM_W-1:0]    cmp_reg, cmp_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [PWM_W-1:0]    out_reload_reg, out_reload_next;
    logic [PWM_W-1:0]    out_compare_reg, out_compare_next;
    logic                out_busy_reg, out_busy_next;
    logic                out_rej_reg, out_rej_next;

    // Melody table
    entry_t              table_mem [TABLE_DEPTH];
    entry_t              rd_data;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [POS_W-1:0]    pos_dec;

    // Datapath helpers
    logic                accept;
    logic                clr_seq;
    logic                to_idle;
    logic [PRE_W-1:0]    den;
    logic [PWM_W:0]      reload_inc;
    logic [PWM_W:0]      cmp_prod;
    logic                pos_in_table;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == ST_IDLE);
    assign pos_dec    = table_pos_reg - POS_W'(1);
    assign pos_in_table = table_pos_reg < POS_W'(TABLE_DEPTH);
    assign den        = PRE_W'(calc_hz_reg) * PRE_W'(PRESCALE_CODE + 1);
    assign reload_inc = {1'b0, full_reg[PWM_W-1:0]} + (PWM_W+1)'(1);
    assign cmp_prod   = (PWM_W+1)'(calc_vol_reg) * (PWM_W+1)'(div_rsp.quotient[STEP_Q_W-1:0]);

    ptms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Write the table on load, read the slot that the sequencer points at, or the one before it for the gap
    assign mem_we  = (state_reg == ST_DECODE) && (cmd_reg == CMD_LOAD)
                     && (32'(slot_reg) < TABLE_DEPTH);
    assign rd_addr = (state_reg == ST_MEL_CHK) ? pos_dec[IDX_W-1:0]
                                               : table_pos_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[IDX_W'(slot_reg)] <= '{dur: dur_reg, hz: hz_reg, vol: vol_reg};
        end
        rd_data <= table_mem[rd_addr];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= MODE_IDLE;
            tick_target_reg  <= '0;
            tick_count_reg   <= '0;
            table_pos_reg    <= '0;
            repeat_count_reg <= '0;
            repeat_limit_reg <= '0;
            gap_length_reg   <= '0;
            note_done_reg    <= 1'b1;
            busy_flag_reg    <= 1'b0;
            reload_reg       <= '0;
            compare_reg      <= '0;
            rej_reg          <= 1'b0;
            kind_reg         <= KIND_TONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            tick_target_reg  <= tick_target_next;
            tick_count_reg   <= tick_count_next;
            table_pos_reg    <= table_pos_next;
            repeat_count_reg <= repeat_count_next;
            repeat_limit_reg <= repeat_limit_next;
            gap_length_reg   <= gap_length_next;
            note_done_reg    <= note_done_next;
            busy_flag_reg    <= busy_flag_next;
            reload_reg       <= reload_next;
            compare_reg      <= compare_next;
            rej_reg          <= rej_next;
            kind_reg         <= kind_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            slot_reg <= req.entry_index;
            dur_reg  <= req.duration_ms;
            hz_reg   <= req.tone_hz;
            vol_reg  <= req.volume_pct;
            rep_reg  <= req.repeat_limit_in;
            gap_reg  <= req.gap_ms;
        end
        calc_hz_reg     <= calc_hz_next;
        calc_vol_reg    <= calc_vol_next;
        calc_len_reg    <= calc_len_next;
        full_reg        <= full_next;
        cmp_reg         <= cmp_next;
        ticks_reg       <= ticks_next;
        out_reload_reg  <= out_reload_next;
        out_compare_reg <= out_compare_next;
        out_busy_reg    <= out_busy_next;
        out_rej_reg     <= out_rej_next;
    end

    // Next state and sequencer updates
    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        tick_target_next  = tick_target_reg;
        tick_count_next   = tick_count_reg;
        table_pos_next    = table_pos_reg;
        repeat_count_next = repeat_count_reg;
        repeat_limit_next = repeat_limit_reg;
        gap_length_next   = gap_length_reg;
        note_done_next    = note_done_reg;
        busy_flag_next    = busy_flag_reg;
        reload_next       = reload_reg;
        compare_next      = compare_reg;
        rej_next          = rej_reg;
        kind_next         = kind_reg;
        calc_hz_next      = calc_hz_reg;
        calc_vol_next     = calc_vol_reg;
        calc_len_next     = calc_len_reg;
        full_next         = full_reg;
        cmp_next          = cmp_reg;
        ticks_next        = ticks_reg;
        out_valid_next    = out_valid_reg;
        out_reload_next   = out_reload_reg;
        out_compare_next  = out_compare_reg;
        out_busy_next     = out_busy_reg;
        out_rej_next      = out_rej_reg;
        div_req           = '0;
        clr_seq           = 1'b0;
        to_idle           = 1'b0;

        // drop the result word once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rej_next   = 1'b0;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_DONE;
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (mode_reg == MODE_TIMED)
                        begin
                            if (tick_count_reg >= tick_target_reg)
                            begin
                                to_idle = 1'b1;
                            end
                            else
                            begin
                                tick_count_next = tick_count_reg + TICK_W'(1);
                            end
                        end
                        else if (mode_reg == MODE_MELODY)
                        begin
                            if (!note_done_reg)
                            begin
                                // advance the running note or end it
                                if (tick_count_reg >= tick_target_reg)
                                begin
                                    tick_count_next  = '0;
                                    tick_target_next = '0;
                                    note_done_next   = 1'b1;
                                end
                                else
                                begin
                                    tick_count_next = tick_count_reg + TICK_W'(1);
                                end
                            end
                            else
                            begin
                                state_next = ST_MEL_CHK;
                            end
                        end
                    end
                    CMD_TONE:
                    begin
                        if ((32'(vol_reg) > MAX_VOL) || (32'(hz_reg) > MAX_HZ)
                            || (hz_reg == '0))
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            clr_seq       = 1'b1;
                            kind_next     = KIND_TONE;
                            calc_hz_next  = hz_reg;
                            calc_vol_next = vol_reg;
                            calc_len_next = dur_reg;
                            state_next    = ST_DEN;
                        end
                    end
                    CMD_LOAD:
                    begin
                        // table write happens on the memory port
                    end
                    CMD_PLAY:
                    begin
                        clr_seq           = 1'b1;
                        repeat_limit_next = rep_reg;
                        gap_length_next   = gap_reg;
                        mode_next         = MODE_MELODY;
                        busy_flag_next    = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        to_idle = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_MEL_CHK:
            begin
                // table data for the current slot is valid here
                if (pos_in_table && (rd_data.hz != '0))
                begin
                    kind_next     = KIND_NOTE;
                    calc_hz_next  = rd_data.hz;
                    calc_vol_next = rd_data.vol;
                    calc_len_next = rd_data.dur;
                    state_next    = ST_DEN;
                end
                else if ((table_pos_reg == '0) || (repeat_count_reg >= repeat_limit_reg))
                begin
                    to_idle    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MEL_GAP;
                end
            end

            ST_MEL_GAP:
            begin
                // silent gap at the last note's frequency
                kind_next     = KIND_GAP;
                calc_hz_next  = rd_data.hz;
                calc_vol_next = '0;
                calc_len_next = gap_length_reg;
                state_next    = ST_DEN;
            end

            ST_DEN:
            begin
                if (den == '0)
                begin
                    full_next  = '1;
                    state_next = ST_RATIO_GO;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(CLOCK_HZ);
                    div_req.divisor  = DIV_W'(den);
                    state_next       = ST_DIV_CLK;
                end
            end

            ST_DIV_CLK:
            begin
                if (div_rsp.done)
                begin
                    full_next  = div_rsp.quotient - DIV_W'(1);
                    state_next = ST_RATIO_GO;
                end
            end

            ST_RATIO_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(reload_inc);
                div_req.divisor  = DIV_W'(CMP_STEP);
                state_next       = ST_DIV_STEP;
            end

            ST_DIV_STEP:
            begin
                if (div_rsp.done)
                begin
                    cmp_next   = cmp_prod[PWM_W-1:0];
                    state_next = ST_TICK_GO;
                end
            end

            ST_TICK_GO:
            begin
                if (full_reg == '0)
                begin
                    ticks_next = (calc_len_reg != '0) ? '1 : '0;
                    state_next = ST_APPLY;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(calc_len_reg) * DIV_W'(MS_SCALE);
                    div_req.divisor  = full_reg;
                    state_next       = ST_DIV_TICK;
                end
            end

            ST_DIV_TICK:
            begin
                if (div_rsp.done)
                begin
                    ticks_next = div_rsp.quotient;
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                reload_next      = full_reg[PWM_W-1:0];
                compare_next     = cmp_reg;
                tick_target_next = ticks_reg;
                state_next       = ST_DONE;
                unique case (kind_reg)
                    KIND_TONE:
                    begin
                        mode_next      = (calc_len_reg != '0) ? MODE_TIMED : MODE_CONT;
                        busy_flag_next = 1'b1;
                    end
                    KIND_NOTE:
                    begin
                        table_pos_next = table_pos_reg + POS_W'(1);
                        note_done_next = 1'b0;
                    end
                    KIND_GAP:
                    begin
                        repeat_count_next = repeat_count_reg + REP_W'(1);
                        table_pos_next    = '0;
                        note_done_next    = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_DONE:
            begin
                // hand the result word over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_reload_next  = reload_reg;
                    out_compare_next = compare_reg;
                    out_busy_next    = busy_flag_reg;
                    out_rej_next     = rej_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // clear the sequencer position and counters
        if (clr_seq || to_idle)
        begin
            tick_target_next  = '0;
            tick_count_next   = '0;
            table_pos_next    = '0;
            repeat_count_next = '0;
            note_done_next    = 1'b1;
        end

        // silence and release
        if (to_idle)
        begin
            mode_next         = MODE_IDLE;
            repeat_limit_next = '0;
            gap_length_next   = '0;
            busy_flag_next    = 1'b0;
            reload_next       = '0;
            compare_next      = '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pwm_reload  = out_reload_reg;
    assign rsp.pwm_compare = out_compare_reg;
    assign rsp.busy_res    = out_busy_reg;
    assign rsp.rejected    = out_rej_reg;

endmodule

@@ src/ptms_div.sv @@
// Restoring divider: one quotient bit per cycle, done pulses after DIV_W steps
module ptms_div
    import ptms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DIV_W:0]       rem_shift;
    logic                 fits;
    logic [DIV_W:0]       rem_sub;

    // Trial subtract for the current bit
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            quo_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
            cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            // shift in the next dividend bit, keep the quotient bit
            rem_reg  <= fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            quo_reg  <= {quo_reg[DIV_W-2:0], fits};
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            run_reg  <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/ptms_check.sv @@
module ptms_check
    import ptms_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [PWM_W-1:0] rsp_reload,
    input logic [PWM_W-1:0] rsp_compare,
    input logic             rsp_busy,
    input logic             rsp_rejected
);

    // one command at a time: ready drops after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("command accepted while previous one still in work");

    // an idle sequencer drives a silent PWM
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_busy |-> (rsp_reload == '0) && (rsp_compare == '0))
    else $error("idle result with nonzero PWM values");

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word withdrawn before taken");

    // a stalled result word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_reload) && $stable(rsp_compare)
            && $stable(rsp_busy) && $stable(rsp_rejected))
    else $error("result payload changed while stalled");

endmodule

bind pwm_tone_melody_sequencer_core ptms_check u_ptms_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_reload   (rsp.pwm_reload),
    .rsp_compare  (rsp.pwm_compare),
    .rsp_busy     (rsp.busy_res),
    .rsp_rejected (rsp.rejected)
);

@@ sim/tb_pwm_tone_melody_sequencer_core.sv @@
`timescale 1ns / 1ps

module tb_pwm_tone_melody_sequencer_core;
    import ptms_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 300;
    localparam int RUN_LIMIT_NS = 20000000;
    localparam int MAX_REPORTS  = 40;
    localparam int CMD_CODES    = 1 << CMD_W;
    localparam int MAX_MEL_TICKS = 160;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] entry_index;
        logic [MS_W-1:0]   duration_ms;
        logic [HZ_W-1:0]   tone_hz;
        logic [VOL_W-1:0]  volume_pct;
        logic [REP_W-1:0]  repeat_limit_in;
        logic [MS_W-1:0]   gap_ms;
    } cmd_word_t;

    typedef struct {
        logic [PWM_W-1:0] pwm_reload;
        logic [PWM_W-1:0] pwm_compare;
        logic             busy_res;
        logic             rejected;
    } pwm_word_t;

    logic clk;
    logic rst_n;

    ptms_req_if req_ch ();
    ptms_rsp_if rsp_ch ();

    pwm_tone_melody_sequencer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Command words waiting to be driven, PWM words waiting to come back
    cmd_word_t cmd_q[$];
    pwm_word_t pwm_due_q[$];

    // Sequencer mirror
    mode_t             seq_mode;
    entry_t            melody_tab [TABLE_DEPTH];
    logic [TICK_W-1:0] note_ticks;
    logic [TICK_W-1:0] ticks_done;
    logic [POS_W-1:0]  tab_pos;
    logic [REP_W-1:0]  reps_done;
    logic [REP_W-1:0]  reps_max;
    logic [MS_W-1:0]   gap_len;
    logic              note_over;
    logic              busy_now;
    logic [PWM_W-1:0]  cur_reload;
    logic [PWM_W-1:0]  cur_compare;

    // Run statistics
    int err_cnt;
    int words_sent;
    int words_checked;
    int tones_rejected;
    int notes_played;
    int gaps_played;
    int melodies_ended;

    // Handshake bookkeeping
    logic      word_taken;
    int        burst_left;
    int        gap_left;
    cmd_word_t drive_w;
    logic [15:0] stall_pat;
    int        pat_left;

    // Timer period in prescaled clocks minus one, 32-bit wrap
    function automatic logic [TICK_W-1:0] timer_span(input logic [HZ_W-1:0] hz);
        logic [63:0] den;
        logic [63:0] quo;
        den = 64'(hz) * 64'(PRESCALE_CODE + 1);
        quo = (den != 64'd0) ? 64'(CLOCK_HZ) / den : 64'd0;
        return TICK_W'(quo - 64'd1);
    endfunction

    function automatic void load_pwm(input logic [HZ_W-1:0] hz, input logic [VOL_W-1:0] vol);
        logic [TICK_W-1:0] span;
        logic [31:0]       rel;
        logic [31:0]       cmp;
        span = timer_span(hz);
        rel  = {16'd0, span[PWM_W-1:0]};
        cmp  = 32'(vol) * ((rel + 32'd1) / CMP_STEP);
        cur_reload  = rel[PWM_W-1:0];
        cur_compare = cmp[PWM_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] note_ticks_for(input logic [MS_W-1:0] len,
                                                         input logic [HZ_W-1:0] hz);
        logic [TICK_W-1:0] span;
        span = timer_span(hz);
        if (span == '0)
            return (len != '0) ? '1 : '0;
        return TICK_W'((64'(len) * MS_SCALE) / 64'(span));
    endfunction

    function automatic void rewind_seq();
        note_ticks = '0;
        ticks_done = '0;
        tab_pos    = '0;
        reps_done  = '0;
        note_over  = 1'b1;
    endfunction

    function automatic void silence();
        rewind_seq();
        seq_mode    = MODE_IDLE;
        reps_max    = '0;
        gap_len     = '0;
        busy_now    = 1'b0;
        cur_reload  = '0;
        cur_compare = '0;
    endfunction

    // One tick of a playing melody: advance or finish the note, fetch the next, repeat or end the melody
    function automatic void melody_advance();
        entry_t           ent;
        logic [HZ_W-1:0]  last_hz;
        if (!note_over) begin
            if (ticks_done >= note_ticks) begin
                ticks_done = '0;
                note_ticks = '0;
                note_over  = 1'b1;
            end else begin
                ticks_done = ticks_done + 1'b1;
            end
        end else if (tab_pos < TABLE_DEPTH && melody_tab[IDX_W'(tab_pos)].hz != '0) begin
            ent = melody_tab[IDX_W'(tab_pos)];
            load_pwm(ent.hz, ent.vol);
            note_ticks = note_ticks_for(ent.dur, ent.hz);
            tab_pos    = tab_pos + 1'b1;
            note_over  = 1'b0;
            notes_played++;
        end else if (tab_pos == '0 || reps_done >= reps_max) begin
            silence();
            melodies_ended++;
        end else begin
            last_hz    = melody_tab[IDX_W'(tab_pos - 1'b1)].hz;
            reps_done  = reps_done + 1'b1;
            note_ticks = note_ticks_for(gap_len, last_hz);
            load_pwm(last_hz, '0);
            tab_pos    = '0;
            note_over  = 1'b0;
            gaps_played++;
        end
    endfunction

    function automatic pwm_word_t step_sequencer(input cmd_word_t w);
        pwm_word_t res;
        res.rejected = 1'b0;
        case (w.cmd)
            CMD_TICK: begin
                if (seq_mode == MODE_TIMED) begin
                    if (ticks_done >= note_ticks)
                        silence();
                    else
                        ticks_done = ticks_done + 1'b1;
                end else if (seq_mode == MODE_MELODY) begin
                    melody_advance();
                end
            end
            CMD_TONE: begin
                if (w.volume_pct > MAX_VOL || w.tone_hz > MAX_HZ || w.tone_hz == '0) begin
                    res.rejected = 1'b1;
                    tones_rejected++;
                end else begin
                    rewind_seq();
                    load_pwm(w.tone_hz, w.volume_pct);
                    if (w.duration_ms != '0) begin
                        note_ticks = note_ticks_for(w.duration_ms, w.tone_hz);
                        seq_mode   = MODE_TIMED;
                    end else begin
                        seq_mode = MODE_CONT;
                    end
                    busy_now = 1'b1;
                end
            end
            CMD_LOAD: begin
                if (w.entry_index < TABLE_DEPTH)
                    melody_tab[w.entry_index] = {w.duration_ms, w.tone_hz, w.volume_pct};
            end
            CMD_PLAY: begin
                rewind_seq();
                reps_max = w.repeat_limit_in;
                gap_len  = w.gap_ms;
                seq_mode = MODE_MELODY;
                busy_now = 1'b1;
            end
            CMD_STOP: silence();
            default: ;
        endcase
        res.pwm_reload  = cur_reload;
        res.pwm_compare = cur_compare;
        res.busy_res    = busy_now;
        return res;
    endfunction

    // Command word builders: fields the command ignores carry random bits
    function automatic cmd_word_t make_word(input logic [CMD_W-1:0] code);
        cmd_word_t w;
        w.cmd             = code;
        w.entry_index     = SLOT_W'($urandom);
        w.duration_ms     = MS_W'($urandom);
        w.tone_hz         = HZ_W'($urandom);
        w.volume_pct      = VOL_W'($urandom);
        w.repeat_limit_in = REP_W'($urandom);
        w.gap_ms          = MS_W'($urandom);
        return w;
    endfunction

    task automatic queue_code(input logic [CMD_W-1:0] code);
        cmd_q.push_back(make_word(code));
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            queue_code(CMD_TICK);
    endtask

    task automatic queue_tone(input int dur, input int hz, input int vol);
        cmd_word_t w;
        w             = make_word(CMD_TONE);
        w.duration_ms = MS_W'(dur);
        w.tone_hz     = HZ_W'(hz);
        w.volume_pct  = VOL_W'(vol);
        cmd_q.push_back(w);
    endtask

    task automatic queue_load(input int idx, input int dur, input int hz, input int vol);
        cmd_word_t w;
        w             = make_word(CMD_LOAD);
        w.entry_index = SLOT_W'(idx);
        w.duration_ms = MS_W'(dur);
        w.tone_hz     = HZ_W'(hz);
        w.volume_pct  = VOL_W'(vol);
        cmd_q.push_back(w);
    endtask

    task automatic queue_play(input int rep, input int gap);
        cmd_word_t w;
        w                 = make_word(CMD_PLAY);
        w.repeat_limit_in = REP_W'(rep);
        w.gap_ms          = MS_W'(gap);
        cmd_q.push_back(w);
    endtask

    // Fill slots 0..len-1 with mostly short notes, terminate a short table, play and queue ticks
    task automatic queue_melody(input int len, input int rep);
        int dur;
        int hz;
        int gap;
        int hi;
        for (int i = 0; i < len; i++) begin
            dur = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(0, 65535);
            hz  = ($urandom_range(0, 3) != 0) ? $urandom_range(2000, MAX_HZ)
                                               : $urandom_range(1, 65535);
            queue_load(i, dur, hz, $urandom_range(0, 255));
        end
        if (len < TABLE_DEPTH)
            queue_load(len, $urandom_range(0, 65535), 0, $urandom_range(0, 255));
        gap = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
        queue_play(rep, gap);
        // cap the tick run so long repeat counts do not swamp the word budget
        hi = len * (rep + 1) * 8 + 12;
        if (hi > MAX_MEL_TICKS)
            hi = MAX_MEL_TICKS;
        queue_ticks($urandom_range(len * 4 + 2, hi));
    endtask

    task automatic queue_bad_tone();
        case ($urandom_range(0, 2))
            0: queue_tone($urandom_range(0, 65535), $urandom_range(1, MAX_HZ),
                          $urandom_range(MAX_VOL + 1, 255));
            1: queue_tone($urandom_range(0, 65535), $urandom_range(MAX_HZ + 1, 65535),
                          $urandom_range(0, 255));
            default: queue_tone($urandom_range(0, 65535), 0, $urandom_range(0, 255));
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Command driver: bursts of words separated by random gaps
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req_ch.valid || word_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    drive_w = cmd_q.pop_front();
                    req_ch.valid           <= 1'b1;
                    req_ch.cmd             <= drive_w.cmd;
                    req_ch.entry_index     <= drive_w.entry_index;
                    req_ch.duration_ms     <= drive_w.duration_ms;
                    req_ch.tone_hz         <= drive_w.tone_hz;
                    req_ch.volume_pct      <= drive_w.volume_pct;
                    req_ch.repeat_limit_in <= drive_w.repeat_limit_in;
                    req_ch.gap_ms          <= drive_w.gap_ms;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 5) == 0) begin
                        burst_left = 64;
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = $urandom_range(0, 8);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: stall on a rotating pattern, reloaded now and then
    always @(negedge clk) begin
        if (rst_n) begin
            rsp_ch.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            if (pat_left > 1) begin
                pat_left--;
            end else begin
                pat_left = $urandom_range(16, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom) | 16'($urandom);
                    default: stall_pat = 16'($urandom) | 16'h0001;
                endcase
            end
        end
    end

    // Sample both channels: predict on accepted commands, check accepted results
    always @(posedge clk) begin
        cmd_word_t acc_w;
        pwm_word_t exp_w;
        word_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            acc_w.cmd             = req_ch.cmd;
            acc_w.entry_index     = req_ch.entry_index;
            acc_w.duration_ms     = req_ch.duration_ms;
            acc_w.tone_hz         = req_ch.tone_hz;
            acc_w.volume_pct      = req_ch.volume_pct;
            acc_w.repeat_limit_in = req_ch.repeat_limit_in;
            acc_w.gap_ms          = req_ch.gap_ms;
            pwm_due_q.push_back(step_sequencer(acc_w));
            words_sent++;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pwm_due_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: result word with none expected, reload %0d compare %0d",
                             $time, rsp_ch.pwm_reload, rsp_ch.pwm_compare);
            end else begin
                exp_w = pwm_due_q.pop_front();
                check_field("pwm_reload", exp_w.pwm_reload, rsp_ch.pwm_reload);
                check_field("pwm_compare", exp_w.pwm_compare, rsp_ch.pwm_compare);
                check_field("busy_res", exp_w.busy_res, rsp_ch.busy_res);
                check_field("rejected", exp_w.rejected, rsp_ch.rejected);
                words_checked++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int rand_start;
        int len;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.cmd             = '0;
        req_ch.entry_index     = '0;
        req_ch.duration_ms     = '0;
        req_ch.tone_hz         = '0;
        req_ch.volume_pct      = '0;
        req_ch.repeat_limit_in = '0;
        req_ch.gap_ms          = '0;
        rsp_ch.ready           = 1'b0;
        word_taken             = 1'b0;
        burst_left             = 1;
        gap_left               = 0;
        stall_pat              = '1;
        pat_left               = 1;
        err_cnt                = 0;
        words_sent             = 0;
        words_checked          = 0;
        tones_rejected         = 0;
        notes_played           = 0;
        gaps_played            = 0;
        melodies_ended         = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            melody_tab[i] = '0;
        silence();

        // Range extremes of a timed tone, short tone expiring, continuous tone
        queue_tone(65535, MAX_HZ, MAX_VOL);
        queue_code(CMD_TICK);
        queue_tone(1, 1, 0);
        queue_ticks(2);
        queue_tone(0, MAX_HZ, 1);
        queue_code(CMD_TICK);
        // Rejected tones: loud, too high, zero, all ones
        queue_tone(5, 440, MAX_VOL + 1);
        queue_tone(5, MAX_HZ + 1, 50);
        queue_tone(5, 0, 50);
        queue_tone(65535, 65535, 255);
        // Stop and two of the unused codes, the first and the last
        queue_code(CMD_STOP);
        queue_code(CMD_W'(int'(CMD_STOP) + 1));
        queue_code(CMD_W'(CMD_CODES - 1));
        // Leading terminator ends a melody on its first tick
        queue_load(0, 65535, 0, 255);
        queue_play(255, 65535);
        queue_ticks(2);
        queue_load(TABLE_DEPTH - 1, 65535, 65535, 255);

        // Full table first so every slot holds a written entry, then the mix
        rand_start = cmd_q.size();
        queue_melody(TABLE_DEPTH, 1);
        while (cmd_q.size() - rand_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: begin
                    len = ($urandom_range(0, 9) == 0) ? TABLE_DEPTH : $urandom_range(1, 4);
                    queue_melody(len, ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 2));
                end
                7, 8, 9: begin
                    queue_tone($urandom_range(1, 4), $urandom_range(2000, MAX_HZ),
                               $urandom_range(0, MAX_VOL));
                    queue_ticks($urandom_range(1, 30));
                end
                10: begin
                    queue_tone(0, $urandom_range(1, MAX_HZ), $urandom_range(0, MAX_VOL));
                    queue_ticks($urandom_range(1, 5));
                    if ($urandom_range(0, 1) != 0)
                        queue_code(CMD_STOP);
                end
                11: queue_tone($urandom_range(0, 65535),
                               ($urandom_range(0, 1) != 0) ? MAX_HZ : 1,
                               ($urandom_range(0, 1) != 0) ? MAX_VOL : 0);
                12, 13: queue_bad_tone();
                14, 15: queue_load($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 255));
                16: queue_code(($urandom_range(0, 1) != 0) ? CMD_STOP
                               : CMD_W'($urandom_range(int'(CMD_STOP) + 1, CMD_CODES - 1)));
                default: cmd_q.push_back(make_word(CMD_W'($urandom)));
            endcase
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every word is taken and answered, then let the block settle
        while (cmd_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (pwm_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command words, checked %0d result words, %0d mismatches.",
                 words_sent, words_checked, err_cnt);
        $display("Saw %0d rejected tones, %0d melody notes, %0d repeat gaps, %0d melody ends.",
                 tones_rejected, notes_played, gaps_played, melodies_ended);
        if (err_cnt == 0 && pwm_due_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
